FILE: design/gslm_pkg.sv
// Shared types and constants for the 3x3 strict local-maximum detector.
package gslm_pkg;

	localparam int CFG_W   = 11;
	localparam int POS_W   = 10;
	localparam int TOTAL_W = 20;
	localparam int QDEPTH  = 4;
	localparam int QAW     = 2;
	localparam int QCW     = 3;

	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic               peak;
		logic               fin;
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
		logic [TOTAL_W-1:0] total;
	} report_t;

endpackage

FILE: design/gslm_if.sv
// Handshake channels for the sample input and the result output.
interface gslm_sample_if #(parameter int HB = 16) ();
	logic                 valid;
	logic                 ready;
	logic signed [HB-1:0] height;

	modport source(output valid, output height, input ready);
	modport sink(input valid, input height, output ready);
endinterface

interface gslm_result_if #(parameter int HB = 16) ();
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic signed [HB-1:0] peak_value;
	logic [9:0]           peak_row;
	logic [9:0]           peak_col;
	logic [19:0]          peak_total;
	logic                 last;

	modport source(output valid, output kind, output peak_value, output peak_row,
		output peak_col, output peak_total, output last, input ready);
	modport sink(input valid, input kind, input peak_value, input peak_row,
		input peak_col, input peak_total, input last, output ready);
endinterface

FILE: design/gslm_front.sv
// Front part: accepts samples, keeps line buffers and the window, finds peaks.
module gslm_front
	import gslm_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [HEIGHT_BITS-1:0] in_height,
	input  logic [QCW-1:0]                q_count,
	output logic                          push,
	output report_t                       push_rep,
	output logic signed [HEIGHT_BITS-1:0] push_value
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HB = HEIGHT_BITS;

	logic [2*HB-1:0] line_mem [MAX_WIDTH];

	logic [CW-1:0]      col_q, row_q, lastidx_q, lastidx_d;
	logic [TOTAL_W-1:0] cnt_q;
	logic signed [HB-1:0] win_q [9];
	logic signed [HB-1:0] win_d [9];

	logic                 v_s1, fin_s1;
	logic signed [HB-1:0] x_s1;
	logic [CW-1:0]        c_s1, r_s1;
	logic [2*HB-1:0]      rd_s1;

	logic acc, peak, greater;

	assign acc      = in_valid && in_ready;
	assign in_ready = (q_count + {{(QCW-1){1'b0}}, v_s1}) < QCW'(QDEPTH);

	always_comb begin
		if (cfg_data < CFG_W'(3)) begin
			lastidx_d = CW'(2);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			lastidx_d = CW'(MAX_WIDTH - 1);
		end else begin
			lastidx_d = CW'(cfg_data - CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			lastidx_q <= CW'(2);
			v_s1      <= 1'b0;
		end else if (cfg_we) begin
			col_q     <= '0;
			row_q     <= '0;
			lastidx_q <= lastidx_d;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (acc) begin
				if (col_q == lastidx_q) begin
					col_q <= '0;
					row_q <= (row_q == lastidx_q) ? '0 : row_q + CW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_s1   <= in_height;
			c_s1   <= col_q;
			r_s1   <= row_q;
			fin_s1 <= (col_q == lastidx_q) && (row_q == lastidx_q);
			rd_s1  <= line_mem[col_q];
		end
		if (v_s1) begin
			line_mem[c_s1] <= {rd_s1[HB-1:0], x_s1};
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_d[k*3+0] = win_q[k*3+1];
			win_d[k*3+1] = win_q[k*3+2];
		end
		win_d[2] = rd_s1[2*HB-1:HB];
		win_d[5] = rd_s1[HB-1:0];
		win_d[8] = x_s1;
		greater = 1'b1;
		for (int k = 0; k < 9; k++) begin
			if (k != 4 && !(win_d[4] > win_d[k])) begin
				greater = 1'b0;
			end
		end
		peak = greater && (r_s1 >= CW'(2)) && (c_s1 >= CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (cfg_we) begin
			cnt_q <= '0;
		end else if (v_s1) begin
			win_q <= win_d;
			if (fin_s1) begin
				cnt_q <= '0;
			end else if (peak) begin
				cnt_q <= cnt_q + TOTAL_W'(1);
			end
		end
	end

	assign push           = v_s1 && (peak || fin_s1);
	assign push_rep.peak  = peak;
	assign push_rep.fin   = fin_s1;
	assign push_rep.row   = POS_W'(r_s1 - CW'(1));
	assign push_rep.col   = POS_W'(c_s1 - CW'(1));
	assign push_rep.total = cnt_q + TOTAL_W'(peak);
	assign push_value     = win_d[4];

endmodule

FILE: design/gslm_queue.sv
// Short queue of classified items between the front and the back.
module gslm_queue
	import gslm_pkg::*;
#(
	parameter int W = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [W-1:0]   push_data,
	input  logic           pop,
	output logic [W-1:0]   head,
	output logic [QCW-1:0] count
);

	logic [W-1:0]   slot_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign head  = slot_q[rd_q];
	assign count = count_q;

endmodule

FILE: design/gslm_back.sv
// Back part: turns queued items into peak reports and summaries.
module gslm_back
	import gslm_pkg::*;
#(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [QCW-1:0]                q_count,
	input  report_t                       head_rep,
	input  logic signed [HEIGHT_BITS-1:0] head_value,
	output logic                          pop,
	gslm_result_if.source                 results
);

	logic phase_q, load, emit_peak;

	assign load      = (q_count != '0) && (!results.valid || results.ready);
	assign emit_peak = head_rep.peak && !phase_q;
	assign pop       = load && !(emit_peak && head_rep.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
			phase_q       <= 1'b0;
		end else begin
			if (load) begin
				results.valid <= 1'b1;
				phase_q       <= emit_peak && head_rep.fin;
			end else if (results.ready) begin
				results.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_peak) begin
				results.kind       <= KIND_PEAK;
				results.peak_value <= head_value;
				results.peak_row   <= head_rep.row;
				results.peak_col   <= head_rep.col;
				results.peak_total <= '0;
				results.last       <= !head_rep.fin;
			end else begin
				results.kind       <= KIND_SUMMARY;
				results.peak_value <= '0;
				results.peak_row   <= '0;
				results.peak_col   <= '0;
				results.peak_total <= head_rep.total;
				results.last       <= 1'b1;
			end
		end
	end

endmodule

FILE: design/grid_strict_local_max_3x3_unit.sv
// Top level of the 3x3 strict local-maximum detector.
//
//   Channel   Direction  Handshake        Carries
//   samples   in         valid / ready    height
//   results   out        valid / ready    kind, peak_value, peak_row, peak_col,
//                                         peak_total, last
//   cfg       in         cfg_we only      grid_size
//
// One sample is taken per clock while the result side keeps up; a sample that
// completes a peak on the last cell of the grid yields a peak report and then
// the summary. A peak report passes the line buffer read register, the queue
// and the output register; the window compare is combinational. The input
// stalls when the queued items and the one in the compare stage fill the
// four-entry queue, which absorbs output stalls. Reset clears the counters and
// the window but not the line buffers. A size write restarts the grid.
module grid_strict_local_max_3x3_unit
	import gslm_pkg::*;
#(
	parameter int MAX_WIDTH   = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	gslm_sample_if.sink      samples,
	gslm_result_if.source    results
);

	localparam int QW = $bits(report_t) + HEIGHT_BITS;

	logic                          push, pop;
	report_t                       push_rep, head_rep;
	logic signed [HEIGHT_BITS-1:0] push_value, head_value;
	logic [QW-1:0]                 head;
	logic [QCW-1:0]                q_count;

	gslm_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.in_height (samples.height),
		.q_count   (q_count),
		.push      (push),
		.push_rep  (push_rep),
		.push_value(push_value)
	);

	gslm_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_rep, push_value}),
		.pop      (pop),
		.head     (head),
		.count    (q_count)
	);

	assign head_rep   = head[QW-1:HEIGHT_BITS];
	assign head_value = head[HEIGHT_BITS-1:0];

	gslm_back #(
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_count   (q_count),
		.head_rep  (head_rep),
		.head_value(head_value),
		.pop       (pop),
		.results   (results)
	);

endmodule
